/* hw/rtl/pfb_pkg.sv */
`timescale 1ns / 1ps

package pfb_pkg;

    typedef enum logic [2:0] {
        OP_SET_PIXEL = 3'd0,
        OP_CLR_PIXEL = 3'd1,
        OP_BLIT_BYTE = 3'd2,
        OP_CLEAR_ALL = 3'd3,
        OP_READ_BYTE = 3'd4
    } op_t;

    localparam int unsigned BLIT_MAX_PAGES = 8;
    localparam int unsigned BLIT_MAX_WIDTH = 128;

    // Widths of the input and output words.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 8;

    // Outcome of locating one operation in the store.
    typedef struct packed {
        logic        en_a;      // first byte lies on screen and is touched
        logic        en_b;      // second byte (unaligned blit) lies on screen
        logic [15:0] wmask;     // bits to replace, low byte for A, high for B
        logic [15:0] wval;      // new values of those bits
        logic        drop;
        logic        last;
        logic [6:0]  col_next;
        logic [2:0]  row_next;
    } loc_t;

endpackage

/* hw/rtl/pfb_locate.sv */
`timescale 1ns / 1ps

module pfb_locate #(
    parameter int unsigned SCREEN_COLUMNS = 128,
    parameter int unsigned SCREEN_PAGES   = 8,
    parameter int unsigned AW             = 10
) (
    input  pfb_pkg::op_t   op,
    input  logic [7:0]     pos_x,
    input  logic [7:0]     pos_y,
    input  logic [6:0]     bitmap_height,
    input  logic [7:0]     bitmap_width,
    input  logic [7:0]     data_byte,
    input  logic [6:0]     col,
    input  logic [2:0]     row,
    output logic [AW-1:0]  addr_a,
    output logic [AW-1:0]  addr_b,
    output pfb_pkg::loc_t  loc
);

    logic [8:0]  x;
    logic [8:0]  y;
    logic [5:0]  page_a;
    logic [5:0]  page_b;
    logic [2:0]  shift;
    logic        x_on;
    logic        pa_on;
    logic        pb_on;
    logic        bottom_off;
    logic [7:0]  h_sum;
    logic [4:0]  pages_raw;
    logic [4:0]  pages;
    logic [7:0]  width;
    logic        col_end;
    logic        row_end;

    assign x      = (op == pfb_pkg::OP_BLIT_BYTE) ? ({1'b0, pos_x} + {2'b00, col})
                                                  : {1'b0, pos_x};
    assign y      = (op == pfb_pkg::OP_BLIT_BYTE) ? ({1'b0, pos_y} + {3'b000, row, 3'b000})
                                                  : {1'b0, pos_y};
    assign page_a = y[8:3];
    assign page_b = page_a + 6'd1;
    assign shift  = y[2:0];

    assign x_on       = 32'(x) < SCREEN_COLUMNS;
    assign pa_on      = 32'(page_a) < SCREEN_PAGES;
    assign pb_on      = 32'(page_b) < SCREEN_PAGES;
    assign bottom_off = (32'(y) + 32'd7) >= SCREEN_PAGES * 8;

    assign addr_a = AW'(32'(page_a) * SCREEN_COLUMNS + 32'(x));
    assign addr_b = AW'(32'(page_b) * SCREEN_COLUMNS + 32'(x));

    // Page count of the bitmap, rounded up and held within one to eight.
    assign h_sum     = {1'b0, bitmap_height} + 8'd7;
    assign pages_raw = h_sum[7:3];
    assign pages     = (pages_raw == 5'd0) ? 5'd1
                     : (32'(pages_raw) > pfb_pkg::BLIT_MAX_PAGES) ? 5'(pfb_pkg::BLIT_MAX_PAGES)
                     : pages_raw;
    assign width     = (bitmap_width == 8'd0) ? 8'd1
                     : (32'(bitmap_width) > pfb_pkg::BLIT_MAX_WIDTH)
                       ? 8'(pfb_pkg::BLIT_MAX_WIDTH) : bitmap_width;

    assign col_end = ({1'b0, col} + 8'd1) >= width;
    assign row_end = ({2'b00, row} + 5'd1) >= pages;

    always_comb begin
        loc = '0;
        loc.col_next = col;
        loc.row_next = row;
        case (op)
            pfb_pkg::OP_SET_PIXEL, pfb_pkg::OP_CLR_PIXEL: begin
                loc.en_a  = x_on && pa_on;
                loc.drop  = !(x_on && pa_on);
                loc.wmask = {8'h00, 8'h01 << shift};
                loc.wval  = (op == pfb_pkg::OP_SET_PIXEL) ? {8'h00, 8'h01 << shift} : 16'h0000;
            end
            pfb_pkg::OP_BLIT_BYTE: begin
                // An unaligned byte straddles two pages of the same column.
                loc.en_a  = x_on && pa_on;
                loc.en_b  = x_on && pb_on && (shift != 3'd0);
                loc.drop  = !x_on || bottom_off;
                loc.wmask = 16'h00FF << shift;
                loc.wval  = {8'h00, data_byte} << shift;
                loc.last  = col_end && row_end;
                if (col_end) begin
                    loc.col_next = 7'd0;
                    loc.row_next = row_end ? 3'd0 : row + 3'd1;
                end else begin
                    loc.col_next = col + 7'd1;
                end
            end
            pfb_pkg::OP_READ_BYTE: begin
                loc.en_a = x_on && pa_on;
                loc.drop = !(x_on && pa_on);
            end
            default: begin
                loc = '0;
                loc.col_next = col;
                loc.row_next = row;
            end
        endcase
    end

endmodule

/* hw/rtl/page_framebuffer_pixel_blitter_core.sv */
`timescale 1ns / 1ps
// Monochrome page-organised frame store with pixel, blit, clear and read operations.
// Input words arrive on the s_ channel; each accepted word gives exactly one result
// word on the m_ channel (read byte in m_tdata, end of bitmap in m_tlast, off-screen
// flag in m_tuser).
// The store is one synchronous memory of SCREEN_PAGES*SCREEN_COLUMNS bytes with a
// registered read. Operations run on it in steps, and no new word is taken meanwhile:
//   read, set/clear pixel and page-aligned blit bytes: locate, one read-modify-write
//   (a read alone for read byte), result; unused codes and items that touch no on-screen byte: locate, result,
//   blit bytes that straddle two pages: a second read-modify-write before the result,
//   clear all: a sweep of the whole store, one byte written per cycle, then the result.
// The result word becomes valid at the same edge at which s_tready rises again.
// These steps follow from the single read and single write port of the store.
// After reset (aresetn low, synchronous) the block sweeps the whole store to zero
// with s_tready low; bitmap counters are cleared at once.
// A finished result sits in an output register; if the receiver stalls, the next word
// is still accepted and processed, and the block then waits to hand over its result.

module page_framebuffer_pixel_blitter_core #(
    parameter int unsigned SCREEN_COLUMNS = 128,
    parameter int unsigned SCREEN_PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], pos_x[10:3], pos_y[18:11], bitmap_height[25:19],
    // bitmap_width[33:26], data_byte[41:34], zero fill[47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // dropped[0]
    output logic        m_tuser
);

    localparam int unsigned DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOCATE = 6'b000010,
        S_MOD_A  = 6'b000100,
        S_MOD_B  = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    pfb_pkg::op_t  op_reg, op_next;
    logic [7:0]    x_reg, x_next;
    logic [7:0]    y_reg, y_next;
    logic [6:0]    h_reg, h_next;
    logic [7:0]    w_reg, w_next;
    logic [7:0]    d_reg, d_next;
    logic [6:0]    col_reg, col_next;
    logic [2:0]    row_reg, row_next;
    pfb_pkg::loc_t loc_reg, loc_next;
    logic [AW-1:0] addr_a_reg, addr_a_next;
    logic [AW-1:0] addr_b_reg, addr_b_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_op_reg, clr_op_next;
    logic [7:0]    rd_reg, rd_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;
    logic          m_user_reg, m_user_next;

    logic [AW-1:0] loc_addr_a;
    logic [AW-1:0] loc_addr_b;
    pfb_pkg::loc_t loc;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q_reg;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    pfb_locate #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES),
        .AW             (AW)
    ) u_locate (
        .op            (op_reg),
        .pos_x         (x_reg),
        .pos_y         (y_reg),
        .bitmap_height (h_reg),
        .bitmap_width  (w_reg),
        .data_byte     (d_reg),
        .col           (col_reg),
        .row           (row_reg),
        .addr_a        (loc_addr_a),
        .addr_b        (loc_addr_b),
        .loc           (loc)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        d_next       = d_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        loc_next     = loc_reg;
        addr_a_next  = addr_a_reg;
        addr_b_next  = addr_b_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_op_next  = clr_op_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        mem_re       = 1'b0;
        mem_raddr    = loc_addr_a;
        mem_we       = 1'b0;
        mem_waddr    = addr_a_reg;
        mem_wdata    = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = pfb_pkg::op_t'(s_tdata[2:0]);
                    x_next     = s_tdata[10:3];
                    y_next     = s_tdata[18:11];
                    h_next     = s_tdata[25:19];
                    w_next     = s_tdata[33:26];
                    d_next     = s_tdata[41:34];
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE: begin
                loc_next    = loc;
                addr_a_next = loc_addr_a;
                addr_b_next = loc_addr_b;
                rd_next     = 8'h00;
                col_next    = loc.col_next;
                row_next    = loc.row_next;
                if (op_reg == pfb_pkg::OP_CLEAR_ALL) begin
                    clr_cnt_next = '0;
                    clr_op_next  = 1'b1;
                    state_next   = S_CLEAR;
                end else if (loc.en_a) begin
                    mem_re     = 1'b1;
                    mem_raddr  = loc_addr_a;
                    state_next = S_MOD_A;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOD_A: begin
                if (op_reg == pfb_pkg::OP_READ_BYTE) begin
                    rd_next = mem_q_reg;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_a_reg;
                    mem_wdata = (mem_q_reg & ~loc_reg.wmask[7:0])
                              | (loc_reg.wval[7:0] & loc_reg.wmask[7:0]);
                end
                if (loc_reg.en_b) begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr_b_reg;
                    state_next = S_MOD_B;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOD_B: begin
                mem_we     = 1'b1;
                mem_waddr  = addr_b_reg;
                mem_wdata  = (mem_q_reg & ~loc_reg.wmask[15:8])
                           | (loc_reg.wval[15:8] & loc_reg.wmask[15:8]);
                state_next = S_DONE;
            end
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 8'h00;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    // The sweep after reset gives no result word.
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_reg;
                    m_last_next  = loc_reg.last;
                    m_user_next  = loc_reg.drop;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            col_reg     <= 7'd0;
            row_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        h_reg      <= h_next;
        w_reg      <= w_next;
        d_reg      <= d_next;
        loc_reg    <= loc_next;
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

endmodule
